@@ rtl/hbae_pkg.sv @@
// ----------------------------------------------------------------------------
// hbae_pkg: shared types, constants and byte functions
// Slot layout of one cell, decimal conversion and slot-to-byte mapping used
// by the front (keep mask) and the back (byte generation).
// ----------------------------------------------------------------------------
package hbae_pkg;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Fixed slot layout of one cell, unused slots are masked off
	localparam int CELL_SLOTS = 54;
	localparam int SLOT_W     = 6;
	localparam int COLOR_LEN  = 19;
	localparam int P_HOME     = 0;
	localparam int P_FG       = 3;
	localparam int P_BG       = 22;
	localparam int P_HALF     = 41;
	localparam int P_ROW      = 44;
	localparam int P_FEND     = 50;

	// Offsets inside one color escape
	localparam int C_DIGITS   = 7;
	localparam int C_LAST     = 18;

	// Byte codes
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBR   = 8'h5B;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_HB0   = 8'hE2;
	localparam logic [7:0] CH_HB1   = 8'h96;
	localparam logic [7:0] CH_HB2   = 8'h80;

	typedef struct packed {
		logic [3:0] hun;
		logic [3:0] ten;
		logic [3:0] one;
	} dec_t;

	typedef dec_t [2:0] color_dec_t;  // [2] red, [1] green, [0] blue

	typedef struct packed {
		logic [CELL_SLOTS-1:0] keep;
		color_dec_t            fg;
		color_dec_t            bg;
	} cmd_t;

	// 8-bit value to three decimal digits by reciprocal multiply
	function automatic dec_t to_dec(input logic [7:0] v);
		logic [13:0] ph;
		logic [7:0]  hund;
		logic [7:0]  r;
		logic [14:0] pt;
		logic [3:0]  t;
		logic [6:0]  tens;
		logic [6:0]  o;
		dec_t        d;
		ph   = {6'd0, v} * 14'd41;
		hund = 8'd100 * {6'd0, ph[13:12]};
		r    = v - hund;
		pt   = {8'd0, r[6:0]} * 15'd205;
		t    = pt[14:11];
		tens = {3'd0, t} * 7'd10;
		o    = r[6:0] - tens;
		d.hun = {2'd0, ph[13:12]};
		d.ten = t;
		d.one = o[3:0];
		return d;
	endfunction

	// Which slots of one color escape are sent
	function automatic logic [COLOR_LEN-1:0] color_keep(input logic send,
			input color_dec_t c);
		logic [COLOR_LEN-1:0] k;
		k = {COLOR_LEN{send}};
		for (int i = 0; i < 3; i++) begin
			k[C_DIGITS + 4*i]     = send && (c[2-i].hun != 4'd0);
			k[C_DIGITS + 4*i + 1] = send && (c[2-i].hun != 4'd0 || c[2-i].ten != 4'd0);
		end
		return k;
	endfunction

	// Byte at one offset of a color escape
	function automatic logic [7:0] color_byte(input logic [4:0] off,
			input logic [7:0] kind, input color_dec_t c);
		logic [4:0] rel;
		logic [3:0] dig;
		logic [7:0] b;
		rel = off - 5'(C_DIGITS);
		dig = 4'd0;
		case (rel[3:2])
			2'd0:    dig = (rel[1:0] == 2'd0) ? c[2].hun : (rel[1:0] == 2'd1) ? c[2].ten : c[2].one;
			2'd1:    dig = (rel[1:0] == 2'd0) ? c[1].hun : (rel[1:0] == 2'd1) ? c[1].ten : c[1].one;
			default: dig = (rel[1:0] == 2'd0) ? c[0].hun : (rel[1:0] == 2'd1) ? c[0].ten : c[0].one;
		endcase
		case (off)
			5'd0:    b = CH_ESC;
			5'd1:    b = CH_LBR;
			5'd2:    b = kind;
			5'd3:    b = CH_EIGHT;
			5'd4:    b = CH_SEMI;
			5'd5:    b = CH_TWO;
			5'd6:    b = CH_SEMI;
			5'(C_LAST): b = CH_M;
			default: b = (rel[1:0] == 2'd3) ? CH_SEMI : (CH_ZERO + {4'd0, dig});
		endcase
		return b;
	endfunction

	// Byte at one slot of the cell
	function automatic logic [7:0] slot_byte(input logic [SLOT_W-1:0] pos,
			input color_dec_t fg, input color_dec_t bg);
		logic [SLOT_W-1:0] fo;
		logic [SLOT_W-1:0] bo;
		logic [7:0]        b;
		fo = pos - SLOT_W'(P_FG);
		bo = pos - SLOT_W'(P_BG);
		if (pos < SLOT_W'(P_FG)) begin
			b = (pos == SLOT_W'(P_HOME)) ? CH_ESC :
				(pos == SLOT_W'(P_HOME + 1)) ? CH_LBR : CH_H;
		end else if (pos < SLOT_W'(P_BG)) begin
			b = color_byte(fo[4:0], CH_THREE, fg);
		end else if (pos < SLOT_W'(P_HALF)) begin
			b = color_byte(bo[4:0], CH_FOUR, bg);
		end else begin
			case (pos)
				SLOT_W'(P_HALF):     b = CH_HB0;
				SLOT_W'(P_HALF + 1): b = CH_HB1;
				SLOT_W'(P_HALF + 2): b = CH_HB2;
				SLOT_W'(P_ROW):      b = CH_ESC;
				SLOT_W'(P_ROW + 1):  b = CH_LBR;
				SLOT_W'(P_ROW + 2):  b = CH_ZERO;
				SLOT_W'(P_ROW + 3):  b = CH_M;
				SLOT_W'(P_ROW + 4):  b = CH_CR;
				SLOT_W'(P_ROW + 5):  b = CH_LF;
				SLOT_W'(P_FEND):     b = CH_ESC;
				SLOT_W'(P_FEND + 1): b = CH_LBR;
				SLOT_W'(P_FEND + 2): b = CH_ZERO;
				default:             b = CH_M;
			endcase
		end
		return b;
	endfunction

endpackage

@@ rtl/hbae_front.sv @@
// ----------------------------------------------------------------------------
// hbae_front: cell intake and classification
// Tracks the last colors sent, decides which escapes a cell needs and builds
// its slot mask and decimal digits for the queue.
// ----------------------------------------------------------------------------
module hbae_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        top_red,
	input  logic [7:0]        top_green,
	input  logic [7:0]        top_blue,
	input  logic [7:0]        bottom_red,
	input  logic [7:0]        bottom_green,
	input  logic [7:0]        bottom_blue,
	input  logic              frame_start,
	input  logic              row_end,
	input  logic              frame_end,
	input  logic              q_full,
	output logic              q_push,
	output hbae_pkg::cmd_t    q_cmd
);
	import hbae_pkg::*;

	logic [23:0] fore_color_q;
	logic        fore_valid_q;
	logic [23:0] back_color_q;
	logic        back_valid_q;

	logic [23:0] fg;
	logic [23:0] bg;
	logic        fg_send;
	logic        bg_send;
	color_dec_t  fg_dec;
	color_dec_t  bg_dec;

	assign fg = {top_red, top_green, top_blue};
	assign bg = {bottom_red, bottom_green, bottom_blue};

	assign fg_send = frame_start || !fore_valid_q || (fore_color_q != fg);
	assign bg_send = frame_start || !back_valid_q || (back_color_q != bg);

	assign fg_dec = {to_dec(top_red), to_dec(top_green), to_dec(top_blue)};
	assign bg_dec = {to_dec(bottom_red), to_dec(bottom_green), to_dec(bottom_blue)};

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.keep = '0;
		q_cmd.keep[P_HOME +: 3]        = {3{frame_start}};
		q_cmd.keep[P_FG +: COLOR_LEN]  = color_keep(fg_send, fg_dec);
		q_cmd.keep[P_BG +: COLOR_LEN]  = color_keep(bg_send, bg_dec);
		q_cmd.keep[P_HALF +: 3]        = 3'b111;
		q_cmd.keep[P_ROW +: 6]         = {6{row_end}};
		q_cmd.keep[P_FEND +: 4]        = {4{frame_end}};
		q_cmd.fg = fg_dec;
		q_cmd.bg = bg_dec;
	end

	// Both resets drop the terminal colors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fore_color_q <= '0;
			fore_valid_q <= 1'b0;
			back_color_q <= '0;
			back_valid_q <= 1'b0;
		end else if (q_push) begin
			fore_color_q <= fg;
			back_color_q <= bg;
			fore_valid_q <= !(row_end || frame_end);
			back_valid_q <= !(row_end || frame_end);
		end
	end

endmodule

@@ rtl/hbae_queue.sv @@
// ----------------------------------------------------------------------------
// hbae_queue: command queue between front and back
// Small register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module hbae_queue #(
	parameter int DEPTH = hbae_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hbae_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output hbae_pkg::cmd_t rd_cmd
);
	import hbae_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/hbae_back.sv @@
// ----------------------------------------------------------------------------
// hbae_back: byte sequencer
// Walks the kept slots of the current cell lowest first, one byte per beat,
// into an output register; the next cell is loaded with the final byte.
// ----------------------------------------------------------------------------
module hbae_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_not_empty,
	input  hbae_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           last_byte
);
	import hbae_pkg::*;

	logic [CELL_SLOTS-1:0] rem_q;
	color_dec_t            fg_q;
	color_dec_t            bg_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  last_q;

	logic [CELL_SLOTS-1:0] rem_nx;
	logic [SLOT_W-1:0]     pos;
	logic                  adv;
	logic                  fin;

	// lowest kept slot
	always_comb begin
		pos = '0;
		for (int i = CELL_SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				pos = SLOT_W'(i);
			end
		end
	end

	assign rem_nx = rem_q & (rem_q - 1'b1);
	assign fin    = (rem_nx == '0);
	assign adv    = (rem_q != '0) && (!out_valid_q || !out_stall);
	assign q_pop  = q_not_empty && ((rem_q == '0) || (adv && fin));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			fg_q <= q_cmd.fg;
			bg_q <= q_cmd.bg;
		end
		if (adv) begin
			out_byte_q <= slot_byte(pos, fg_q, bg_q);
			last_q     <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				rem_q <= q_cmd.keep;
			end else if (adv) begin
				rem_q <= rem_nx;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

endmodule

@@ rtl/half_block_ansi_cell_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// half_block_ansi_cell_encoder_unit: true-color half-block cell encoder
// A cell passes the queue, the slot mask register and the output register.
// Throughput: one output byte per cycle while out_stall is low; a cell is
//   3 to 54 bytes long (up to 44 with home and both colors changed).
// The output byte register sets the rate; cells queue up behind it.
// Reset: asynchronous, clears color memory (no color valid), queue, output.
// ----------------------------------------------------------------------------
module half_block_ansi_cell_encoder_unit #(
	parameter int QUEUE_DEPTH = hbae_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// cell input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] top_red,
	input  logic [7:0] top_green,
	input  logic [7:0] top_blue,
	input  logic [7:0] bottom_red,
	input  logic [7:0] bottom_green,
	input  logic [7:0] bottom_blue,
	input  logic       frame_start,
	input  logic       row_end,
	input  logic       frame_end,
	// byte output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_byte
);
	import hbae_pkg::*;

	// Front to queue
	logic q_push;
	logic q_full;
	cmd_t q_wr_cmd;

	// Queue to back
	logic q_pop;
	logic q_not_empty;
	cmd_t q_rd_cmd;

	// Front: compares each cell against the last colors sent and turns it into
	// a slot mask over the fixed 54-slot layout (home, fg escape, bg escape,
	// half block, row reset, frame reset) plus the decimal digits of both
	// colors. Leading-zero digits simply drop out of the mask. A cell is taken
	// whenever the queue has room, so the front never waits on output beats.
	hbae_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.top_red      (top_red),
		.top_green    (top_green),
		.top_blue     (top_blue),
		.bottom_red   (bottom_red),
		.bottom_green (bottom_green),
		.bottom_blue  (bottom_blue),
		.frame_start  (frame_start),
		.row_end      (row_end),
		.frame_end    (frame_end),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_wr_cmd)
	);

	// Decouples cell intake from byte output
	hbae_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_cmd    (q_wr_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_cmd    (q_rd_cmd)
	);

	// Back: emits the kept slots in order, one beat per cycle while out_stall
	// is low; the next cell is pulled from the queue in the same cycle as the
	// final byte, so consecutive queued cells stream without a gap.
	hbae_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_cmd       (q_rd_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_byte   (last_byte)
	);

endmodule

@@ test/tb_half_block_ansi_cell_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_half_block_ansi_cell_encoder_unit: self-checking bench for the cell encoder
// Sends directed corner cells, then framed random traffic mixed with noise
// cells. Each accepted cell is run through a byte-stream predictor, and every
// output beat is checked in order against it. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_half_block_ansi_cell_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import hbae_pkg::*;

	localparam int CLK_PERIOD  = 10;
	localparam int RESET_LEN   = 12;
	localparam int RAND_CELLS  = 110;   // random part, in cells
	localparam int CALM_CELLS  = 25;    // closing stretch with no gaps or stalls
	localparam int QUIET_LIMIT = 2000;  // cycles with no beat on either side
	localparam int TAIL_CYCLES = 64;    // longer than one full cell plus latency
	localparam int SHOW_MAX    = 10;

	// One terminal cell as it is presented on the input channel
	typedef struct {
		logic [7:0] top_r, top_g, top_b;
		logic [7:0] bot_r, bot_g, bot_b;
		logic       frame_start, row_end, frame_end;
	} cell_t;

	// One byte of the terminal stream as it leaves the block
	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_beat_t;

	// Predicts the byte stream of each cell and checks the output against it.
	// Holds its own copy of the last colors sent and their valid flags.
	class cell_stream_board;
		logic [23:0]  fg_color = '0;
		logic [23:0]  bg_color = '0;
		bit           fg_known;
		bit           bg_known;
		logic [7:0]   cell_bytes[$];
		stream_beat_t due[$];
		int           failures;
		int           beats_seen;

		function void flag(string what);
			failures++;
			if (failures <= SHOW_MAX)
				$display("%s", what);
		endfunction

		function void put_dec(logic [7:0] v);
			if (v >= 100) cell_bytes.push_back(CH_ZERO + 8'(v / 100));
			if (v >= 10) cell_bytes.push_back(CH_ZERO + 8'((v / 10) % 10));
			cell_bytes.push_back(CH_ZERO + 8'(v % 10));
		endfunction

		// ESC [ kind 8 ; 2 ; r ; g ; b m
		function void put_color(logic [7:0] kind, logic [23:0] rgb);
			cell_bytes.push_back(CH_ESC);
			cell_bytes.push_back(CH_LBR);
			cell_bytes.push_back(kind);
			cell_bytes.push_back(CH_EIGHT);
			cell_bytes.push_back(CH_SEMI);
			cell_bytes.push_back(CH_TWO);
			cell_bytes.push_back(CH_SEMI);
			put_dec(rgb[23:16]);
			cell_bytes.push_back(CH_SEMI);
			put_dec(rgb[15:8]);
			cell_bytes.push_back(CH_SEMI);
			put_dec(rgb[7:0]);
			cell_bytes.push_back(CH_M);
		endfunction

		function void put_reset();
			cell_bytes.push_back(CH_ESC);
			cell_bytes.push_back(CH_LBR);
			cell_bytes.push_back(CH_ZERO);
			cell_bytes.push_back(CH_M);
		endfunction

		function void note_cell(cell_t c);
			logic [23:0] top;
			logic [23:0] bot;
			top = {c.top_r, c.top_g, c.top_b};
			bot = {c.bot_r, c.bot_g, c.bot_b};
			cell_bytes.delete();
			if (c.frame_start) begin
				cell_bytes.push_back(CH_ESC);
				cell_bytes.push_back(CH_LBR);
				cell_bytes.push_back(CH_H);
				fg_known = 1'b0;
				bg_known = 1'b0;
			end
			if (!fg_known || fg_color != top) begin
				put_color(CH_THREE, top);
				fg_color = top;
				fg_known = 1'b1;
			end
			if (!bg_known || bg_color != bot) begin
				put_color(CH_FOUR, bot);
				bg_color = bot;
				bg_known = 1'b1;
			end
			cell_bytes.push_back(CH_HB0);
			cell_bytes.push_back(CH_HB1);
			cell_bytes.push_back(CH_HB2);
			if (c.row_end) begin
				put_reset();
				cell_bytes.push_back(CH_CR);
				cell_bytes.push_back(CH_LF);
				fg_known = 1'b0;
				bg_known = 1'b0;
			end
			if (c.frame_end) begin
				put_reset();
				fg_known = 1'b0;
				bg_known = 1'b0;
			end
			foreach (cell_bytes[i])
				due.push_back('{data: cell_bytes[i], last: (i == cell_bytes.size() - 1)});
		endfunction

		function void check_byte(logic [7:0] data, logic last);
			stream_beat_t want;
			beats_seen++;
			if (due.size() == 0) begin
				flag($sformatf("beat %0d: unexpected byte %h last %b",
					beats_seen, data, last));
				return;
			end
			want = due.pop_front();
			if (data !== want.data || last !== want.last)
				flag($sformatf("beat %0d: expected byte %h last %b, got byte %h last %b",
					beats_seen, want.data, want.last, data, last));
		endfunction
	endclass

	// Block ports; the inputs are known from time zero
	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       in_valid     = 1'b0;
	logic       in_stall;
	logic [7:0] top_red      = '0;
	logic [7:0] top_green    = '0;
	logic [7:0] top_blue     = '0;
	logic [7:0] bottom_red   = '0;
	logic [7:0] bottom_green = '0;
	logic [7:0] bottom_blue  = '0;
	logic       frame_start  = 1'b0;
	logic       row_end      = 1'b0;
	logic       frame_end    = 1'b0;
	logic       out_valid;
	logic       out_stall    = 1'b0;
	logic [7:0] out_byte;
	logic       last_byte;

	// Idle switches, flipped per frame or noise cell so that quiet stretches occur too
	bit tx_gaps_on   = 1'b1;
	bit rx_stalls_on = 1'b1;

	cell_stream_board board = new;
	int               cells_sent;
	int               quiet_cycles;

	half_block_ansi_cell_encoder_unit dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Monitor: all sampling happens at the rising edge, before the drivers'
	// nonblocking updates land, so a beat is seen exactly as the block saw it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			board.note_cell('{top_red, top_green, top_blue,
				bottom_red, bottom_green, bottom_blue,
				frame_start, row_end, frame_end});
		if (arst_n && out_valid && !out_stall)
			board.check_byte(out_byte, last_byte);
	end

	// Watchdog: any beat on either side restarts the count, and a run that
	// reaches QUIET_LIMIT without one ends as failed.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Byte sink: random stall bursts while enabled
	initial begin
		forever begin
			@(posedge clk);
			if (rx_stalls_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic cell_t make_cell(logic [23:0] top, logic [23:0] bot,
			logic fs, logic re, logic fe);
		cell_t c;
		{c.top_r, c.top_g, c.top_b} = top;
		{c.bot_r, c.bot_g, c.bot_b} = bot;
		c.frame_start = fs;
		c.row_end     = re;
		c.frame_end   = fe;
		return c;
	endfunction

	// Color channel values weighted toward the 1/2/3-digit boundaries
	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 5))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'($urandom_range(1, 9));
			3:       return 8'($urandom_range(10, 99));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [23:0] pick_color();
		return {pick_level(), pick_level(), pick_level()};
	endfunction

	// Present one cell and hold it until the block takes it. An optional idle
	// gap goes in front. Called on the edge that took the previous cell, so
	// in_valid gets exactly one update in that step.
	task automatic send_cell(input cell_t c);
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		top_red      <= c.top_r;
		top_green    <= c.top_g;
		top_blue     <= c.top_b;
		bottom_red   <= c.bot_r;
		bottom_green <= c.bot_g;
		bottom_blue  <= c.bot_b;
		frame_start  <= c.frame_start;
		row_end      <= c.row_end;
		frame_end    <= c.frame_end;
		do @(posedge clk); while (in_stall);
		cells_sent++;
	endtask

	initial begin
		cell_t       c;
		logic [23:0] fg_prev;
		logic [23:0] bg_prev;
		int          stop_at;
		int          cols;
		int          rows;
		bit          last_cell;

		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners
		send_cell(make_cell(24'h000000, 24'h000000, 1, 0, 0));  // home, zeros as "0"
		send_cell(make_cell(24'h000000, 24'h000000, 0, 0, 0));  // nothing changed
		send_cell(make_cell(24'hFFFFFF, 24'hFFFFFF, 0, 0, 0));  // three-digit values
		send_cell(make_cell(24'hFFFFFF, 24'h000000, 0, 0, 0));  // background only
		send_cell(make_cell(24'h090A63, 24'h000000, 0, 0, 0));  // foreground only, 9/10/99
		send_cell(make_cell(24'h090A63, 24'h64C7C8, 0, 1, 0));  // 100/199/200, row end
		send_cell(make_cell(24'h090A63, 24'h64C7C8, 0, 0, 0));  // resent after row end
		send_cell(make_cell(24'h123456, 24'h654321, 0, 0, 1));  // frame end alone
		send_cell(make_cell(24'h123456, 24'h654321, 0, 0, 0));  // resent after reset
		send_cell(make_cell(24'h123456, 24'h654321, 1, 0, 0));  // frame start mid-row
		send_cell(make_cell(24'hAA55AA, 24'h55AA55, 0, 0, 0));  // alternating bits
		send_cell(make_cell(24'h55AA55, 24'hAA55AA, 0, 0, 0));
		send_cell(make_cell(24'hFFFFFF, 24'hFFFFFF, 1, 1, 1));  // longest cell
		send_cell(make_cell(24'hFFFFFF, 24'hFFFFFF, 0, 1, 1));  // row and frame end
		send_cell(make_cell(24'h000000, 24'hFFFFFF, 1, 0, 1));  // start and end together
		send_cell(make_cell(24'h808080, 24'h7F7F7F, 0, 1, 0));
		send_cell(make_cell(24'h010203, 24'h010203, 1, 1, 0));

		// Random part: mostly whole frames with random content and runs of
		// repeated colors, the rest lone cells with random flags.
		stop_at = cells_sent + RAND_CELLS;
		fg_prev = pick_color();
		bg_prev = pick_color();
		while (cells_sent < stop_at) begin
			if (cells_sent >= stop_at - CALM_CELLS) begin
				tx_gaps_on   = 1'b0;
				rx_stalls_on <= 1'b0;
			end else begin
				tx_gaps_on   = ($urandom_range(0, 3) != 0);
				rx_stalls_on <= ($urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 4) == 0) begin
				// noise cell
				c = make_cell(24'($urandom), 24'($urandom), $urandom_range(0, 3) == 0,
					$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
				send_cell(c);
			end else begin
				cols = $urandom_range(1, 6);
				rows = $urandom_range(1, 4);
				for (int r = 0; r < rows; r++) begin
					for (int k = 0; k < cols; k++) begin
						if ($urandom_range(0, 2) == 0) fg_prev = pick_color();
						if ($urandom_range(0, 2) == 0) bg_prev = pick_color();
						last_cell = (r == rows - 1) && (k == cols - 1);
						c = make_cell(fg_prev, bg_prev, r == 0 && k == 0, k == cols - 1,
							last_cell);
						// now and then a broken frame: one flag flipped
						if ($urandom_range(0, 19) == 0) begin
							case ($urandom_range(0, 2))
								0:       c.frame_start = ~c.frame_start;
								1:       c.row_end     = ~c.row_end;
								default: c.frame_end   = ~c.frame_end;
							endcase
						end
						send_cell(c);
					end
				end
			end
		end
		in_valid <= 1'b0;

		// Drain, then watch a while longer for stray beats
		while (board.due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
